// ===== hdl/pn_pkg.sv =====
// ----------------------------------------------------------------------------
// pn_pkg
// Shared types and constants for the path normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pn_pkg;

   localparam int CHAR_W      = 8;
   localparam int LIMIT_W     = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int NUM_RES     = 5;
   localparam int RES_CNT_W   = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2f;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5c;
   localparam logic [CHAR_W-1:0] CH_DOT       = 8'h2e;
   localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3a;
   localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7a;
   localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5a;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BACKSLASH = 2'd0,
      CSR_DRIVE     = 2'd1,
      CSR_UNC       = 2'd2,
      CSR_LIMIT     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_D1    = 3'd1,
      PH_PRE   = 3'd2,
      PH_S1    = 3'd3,
      PH_PDOT  = 3'd4,
      PH_SEP   = 3'd5,
      PH_DOT   = 3'd6,
      PH_COMP  = 3'd7
   } phase_type;

   typedef struct packed {
      logic               backslash_separator;
      logic               drive_letters_on;
      logic               unc_prefix_on;
      logic [LIMIT_W-1:0] length_limit;
   } cfg_type;

   // results caused by one input byte: up to five chars, then maybe a terminator
   typedef struct packed {
      logic [NUM_RES-1:0][CHAR_W-1:0] ch;
      logic [RES_CNT_W-1:0]           n;
      logic                           term;
      logic                           trunc;
   } bundle_type;

endpackage

`default_nettype wire

// ===== hdl/pn_stream_if.sv =====
// ----------------------------------------------------------------------------
// pn_stream_if
// Valid/ready channels for path bytes in and normalized bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

interface pn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;
   logic       truncated;

   modport source (output valid, output out_char, output last, output truncated, input ready);
   modport sink   (input valid, input out_char, input last, input truncated, output ready);
endinterface

`default_nettype wire

// ===== hdl/pn_front.sv =====
// ----------------------------------------------------------------------------
// pn_front
// Accepts path bytes, runs the normalizing state machine and the length
// limit, and hands the resulting output bytes to the queue as one bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module pn_front
   import pn_pkg::*;
#(
   parameter int MAX_LIMIT = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   input  wire logic [CHAR_W-1:0] in_char,
   output logic                   in_ready,
   input  wire logic              q_full,
   output logic                   push,
   output bundle_type             push_data
);

   localparam int OCW  = $clog2(MAX_LIMIT);
   localparam int CMPW = (LIMIT_W > OCW + 1) ? LIMIT_W : OCW + 1;

   typedef struct packed {
      logic [OCW-1:0]                 oc;
      logic                           los;
      logic                           cut;
      logic [RES_CNT_W-1:0]           n;
      logic [NUM_RES-1:0][CHAR_W-1:0] ch;
   } work_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_SEP,
      TAIL_COMP
   } tail_type;

   phase_type         phase_ff, phase_in;
   logic [CHAR_W-1:0] held_ff, held_in;
   logic              hc_ff, hc_in;
   logic              ds_ff, ds_in;
   logic [OCW-1:0]    oc_ff, oc_in;
   logic              los_ff, los_in;
   logic              cut_ff, cut_in;

   logic [CMPW-1:0]   lim_ext;
   logic [OCW-1:0]    lim_m1;
   logic              accept;
   logic              c_zero, c_sep, c_dot, c_colon, c_letter;
   logic              drive_flush;
   bundle_type        bundle;

   function automatic work_type f_emit(input work_type w_i, input logic [CHAR_W-1:0] c,
                                       input logic [OCW-1:0] lm);
      work_type w;
      w = w_i;
      if (w.oc < lm) begin
         w.ch[w.n] = c;
         w.n       = w.n + RES_CNT_W'(1);
         w.oc      = w.oc + OCW'(1);
         w.los     = (c == CH_SLASH);
      end else begin
         w.cut = 1'b1;
      end
      return w;
   endfunction

   function automatic work_type f_flush(input work_type w_i, input logic [CHAR_W-1:0] l,
                                        input logic active, input logic [OCW-1:0] lm);
      work_type          w;
      logic [CHAR_W-1:0] lc;
      w  = w_i;
      lc = l;
      if (l >= CH_UPPER_A && l <= CH_UPPER_Z) begin
         lc = l + (CH_LOWER_A - CH_UPPER_A);
      end
      if (active) begin
         w = f_emit(w, lc, lm);
         w = f_emit(w, CH_COLON, lm);
      end
      return w;
   endfunction

   function automatic work_type f_start(input work_type w_i, input logic [CHAR_W-1:0] c,
                                        input logic dot, input logic [OCW-1:0] lm);
      work_type w;
      w = w_i;
      if (w.oc != '0 && !w.los) begin
         w = f_emit(w, CH_SLASH, lm);
      end
      if (dot) begin
         w = f_emit(w, CH_DOT, lm);
      end
      w = f_emit(w, c, lm);
      return w;
   endfunction

   // effective limit minus one, clamped to 1..MAX_LIMIT
   assign lim_ext = CMPW'(cfg.length_limit);

   always_comb begin
      if (lim_ext == '0) begin
         lim_m1 = '0;
      end else if (lim_ext > CMPW'(MAX_LIMIT)) begin
         lim_m1 = OCW'(MAX_LIMIT - 1);
      end else begin
         lim_m1 = OCW'(lim_ext - CMPW'(1));
      end
   end

   assign c_zero   = (in_char == CH_NUL);
   assign c_sep    = (in_char == CH_SLASH) ||
                     (cfg.backslash_separator && in_char == CH_BACKSLASH);
   assign c_dot    = (in_char == CH_DOT);
   assign c_colon  = (in_char == CH_COLON);
   assign c_letter = (in_char >= CH_LOWER_A && in_char <= CH_LOWER_Z) ||
                     (in_char >= CH_UPPER_A && in_char <= CH_UPPER_Z);
   assign drive_flush = ds_ff && hc_ff;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      work_type w;
      logic     fin;
      logic     pass;
      logic     pre;
      tail_type tail;

      w        = '0;
      w.oc     = oc_ff;
      w.los    = los_ff;
      w.cut    = cut_ff;
      fin      = 1'b0;
      pass     = 1'b0;
      pre      = 1'b0;
      tail     = TAIL_NONE;
      phase_in = phase_ff;
      held_in  = held_ff;
      hc_in    = hc_ff;
      ds_in    = ds_ff;

      unique case (phase_ff)
         PH_START: begin
            if (cfg.drive_letters_on && c_letter) begin
               held_in  = in_char;
               hc_in    = 1'b1;
               phase_in = PH_D1;
            end else begin
               pre = 1'b1;
            end
         end
         PH_D1: begin
            if (c_colon) begin
               ds_in    = 1'b1;
               phase_in = PH_PRE;
            end else begin
               // held letter was not a drive, it opens a plain component
               hc_in    = 1'b0;
               w        = f_start(w, held_ff, 1'b0, lim_m1);
               phase_in = PH_COMP;
               tail     = TAIL_COMP;
            end
         end
         PH_PRE: begin
            pre = 1'b1;
         end
         PH_S1: begin
            w = f_emit(w, CH_SLASH, lim_m1);
            if (c_sep) begin
               w        = f_emit(w, CH_SLASH, lim_m1);
               phase_in = PH_SEP;
            end else begin
               tail = TAIL_SEP;
            end
         end
         PH_PDOT: begin
            if (c_zero) begin
               // bare '.' passes through, drive letter keeps its case
               if (drive_flush) begin
                  w = f_emit(w, held_ff, lim_m1);
                  w = f_emit(w, CH_COLON, lim_m1);
               end
               w    = f_emit(w, CH_DOT, lim_m1);
               fin  = 1'b1;
               pass = 1'b1;
            end else if (c_sep) begin
               w        = f_flush(w, held_ff, drive_flush, lim_m1);
               hc_in    = 1'b0;
               w        = f_emit(w, CH_DOT, lim_m1);
               w        = f_emit(w, CH_SLASH, lim_m1);
               phase_in = PH_SEP;
            end else begin
               w        = f_flush(w, held_ff, drive_flush, lim_m1);
               hc_in    = 1'b0;
               w        = f_start(w, in_char, 1'b1, lim_m1);
               phase_in = PH_COMP;
            end
         end
         PH_SEP: begin
            tail = TAIL_SEP;
         end
         PH_DOT: begin
            if (c_zero) begin
               fin = 1'b1;
            end else if (c_sep) begin
               phase_in = PH_SEP;
            end else begin
               w        = f_start(w, in_char, 1'b1, lim_m1);
               phase_in = PH_COMP;
            end
         end
         PH_COMP: begin
            tail = TAIL_COMP;
         end
         default: begin
            tail = TAIL_COMP;
         end
      endcase

      // prefix position: after start or after a drive
      if (pre) begin
         if (c_zero) begin
            w     = f_flush(w, held_ff, drive_flush, lim_m1);
            hc_in = 1'b0;
            fin   = 1'b1;
         end else if (c_sep) begin
            w     = f_flush(w, held_ff, drive_flush, lim_m1);
            hc_in = 1'b0;
            if (cfg.unc_prefix_on) begin
               phase_in = PH_S1;
            end else begin
               w        = f_emit(w, CH_SLASH, lim_m1);
               phase_in = PH_SEP;
            end
         end else if (c_dot) begin
            phase_in = PH_PDOT;
         end else begin
            w     = f_flush(w, held_ff, drive_flush, lim_m1);
            hc_in = 1'b0;
            tail  = TAIL_SEP;
         end
      end

      case (tail)
         TAIL_SEP: begin
            if (c_zero) begin
               fin = 1'b1;
            end else if (c_sep) begin
               phase_in = PH_SEP;
            end else if (c_dot) begin
               phase_in = PH_DOT;
            end else begin
               w        = f_start(w, in_char, 1'b0, lim_m1);
               phase_in = PH_COMP;
            end
         end
         TAIL_COMP: begin
            if (c_zero) begin
               fin = 1'b1;
            end else if (c_sep) begin
               phase_in = PH_SEP;
            end else begin
               w        = f_emit(w, in_char, lim_m1);
               phase_in = PH_COMP;
            end
         end
         default: begin
         end
      endcase

      // root slash for an empty path or a bare drive
      if (fin && !pass && (w.oc == '0 || (ds_ff && w.oc == OCW'(2)))) begin
         w = f_emit(w, CH_SLASH, lim_m1);
      end

      bundle.ch    = w.ch;
      bundle.n     = w.n;
      bundle.term  = fin;
      bundle.trunc = fin && w.cut;

      if (fin) begin
         phase_in = PH_START;
         held_in  = '0;
         hc_in    = 1'b0;
         ds_in    = 1'b0;
         oc_in    = '0;
         los_in   = 1'b0;
         cut_in   = 1'b0;
      end else begin
         oc_in    = w.oc;
         los_in   = w.los;
         cut_in   = w.cut;
      end
   end

   assign push      = accept && (bundle.n != '0 || bundle.term);
   assign push_data = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         held_ff  <= '0;
         hc_ff    <= 1'b0;
         ds_ff    <= 1'b0;
         oc_ff    <= '0;
         los_ff   <= 1'b0;
         cut_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         hc_ff    <= hc_in;
         ds_ff    <= ds_in;
         oc_ff    <= oc_in;
         los_ff   <= los_in;
         cut_ff   <= cut_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pn_queue.sv =====
// ----------------------------------------------------------------------------
// pn_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pn_queue
   import pn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_data,
   output logic            full,
   output logic            head_valid,
   output bundle_type      head,
   input  wire logic       pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pn_back.sv =====
// ----------------------------------------------------------------------------
// pn_back
// Takes bundles off the queue and sends their bytes one transfer at a time,
// closing a path with its terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module pn_back
   import pn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire bundle_type        q_head,
   output logic                   q_pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [CHAR_W-1:0]      out_char,
   output logic                   out_last,
   output logic                   out_truncated
);

   bundle_type           cur_ff, cur_in;
   logic                 valid_ff, valid_in;
   logic [RES_CNT_W-1:0] idx_ff, idx_in;
   logic [RES_CNT_W-1:0] total;
   logic                 at_end;
   logic                 fire;
   logic                 load;

   assign total  = cur_ff.n + RES_CNT_W'(cur_ff.term);
   assign at_end = (RES_CNT_W'(idx_ff + RES_CNT_W'(1)) == total);
   assign fire   = valid_ff && out_ready;
   assign load   = q_valid && (!valid_ff || (fire && at_end));
   assign q_pop  = load;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         cur_in   = q_head;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (fire && at_end) begin
         valid_in = 1'b0;
         idx_in   = '0;
      end else if (fire) begin
         idx_in = idx_ff + RES_CNT_W'(1);
      end
   end

   // bytes first, terminator after them
   always_comb begin
      if (idx_ff < cur_ff.n) begin
         out_char      = cur_ff.ch[idx_ff];
         out_last      = 1'b0;
         out_truncated = 1'b0;
      end else begin
         out_char      = CH_NUL;
         out_last      = 1'b1;
         out_truncated = cur_ff.trunc;
      end
   end

   assign out_valid = valid_ff;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/path_normalizer.sv =====
// Throughput: one byte per cycle while each byte yields at most one result
// and the result port is not stalled; a byte with several results holds the
// single result port for one transfer per result. The front runs at one byte
// per cycle while the queue has room; the rate is set by the result port.
// Reset (synchronous, active high) clears path state, empties the queue and
// restores register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// path_normalizer
// Streaming path normalizer: drive and UNC prefixes, separator folding,
// dot removal and an output length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module path_normalizer
   import pn_pkg::*;
#(
   parameter int MAX_LIMIT = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   pn_req_if.sink                    req_chan,
   pn_rsp_if.source                  rsp_chan,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LIMIT_W-1:0]   csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       q_full;
   logic       push;
   bundle_type push_data;
   logic       q_valid;
   bundle_type q_head;
   logic       q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BACKSLASH: cfg_in.backslash_separator = csr_wdata[0];
            CSR_DRIVE:     cfg_in.drive_letters_on    = csr_wdata[0];
            CSR_UNC:       cfg_in.unc_prefix_on       = csr_wdata[0];
            CSR_LIMIT:     cfg_in.length_limit        = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backslash_separator <= 1'b0;
         cfg_ff.drive_letters_on    <= 1'b0;
         cfg_ff.unc_prefix_on       <= 1'b0;
         cfg_ff.length_limit        <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pn_front #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_char   (req_chan.in_char),
      .in_ready  (req_chan.ready),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   pn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head),
      .pop        (q_pop)
   );

   pn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_char      (rsp_chan.out_char),
      .out_last      (rsp_chan.last),
      .out_truncated (rsp_chan.truncated)
   );

endmodule

`default_nettype wire

// ===== tb/sv/path_normalizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_normalizer_tb
// Streams paths into the normalizer under random burst gaps and result
// stalls, predicts every output byte and checks each result transfer.
// ----------------------------------------------------------------------------

module path_normalizer_tb;
   import pn_pkg::*;

   localparam int          MAX_LIM     = 4096;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          DRAIN_PAD   = 8;
   localparam int          PHASE_ITEMS = 20;
   localparam int          RAND_PHASES = 8;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              trunc;
   } out_byte_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]   csr_wdata;

   pn_req_if req_if ();
   pn_rsp_if rsp_if ();

   path_normalizer #(.MAX_LIMIT(MAX_LIM)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // path bytes waiting to be sent, and normalized bytes still to come
   logic [CHAR_W-1:0] pending_q[$];
   out_byte_type      norm_q[$];

   int error_count;
   int cycle_count;
   int bytes_in;
   int bytes_checked;
   int paths_done;
   int paths_cut;

   // mirror of the registers and of the per-path state
   cfg_type           cfg_m;
   phase_type         ph_m;
   logic [CHAR_W-1:0] held_letter;
   logic [1:0]        held_cnt;
   int unsigned       out_cnt;
   bit                drive_seen_m;
   bit                slash_last_m;
   bit                cut_m;
   int                step_n;

   task automatic report_mismatch(string what);
      $display("MISMATCH @%0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic void reset_path();
      ph_m         = PH_START;
      held_letter  = CH_NUL;
      held_cnt     = 2'd0;
      out_cnt      = 0;
      drive_seen_m = 1'b0;
      slash_last_m = 1'b0;
      cut_m        = 1'b0;
   endfunction

   function automatic void put_byte(logic [CHAR_W-1:0] ch, logic lst, logic tr);
      out_byte_type r;
      if (step_n >= NUM_RES) return;
      r.ch    = ch;
      r.last  = lst;
      r.trunc = tr;
      norm_q.push_back(r);
      step_n++;
   endfunction

   function automatic void send_char(logic [CHAR_W-1:0] ch);
      int unsigned lim;
      lim = cfg_m.length_limit;
      if (lim > MAX_LIM) lim = MAX_LIM;
      if (lim == 0) lim = 1;
      if (out_cnt < lim - 1) begin
         put_byte(ch, 1'b0, 1'b0);
         out_cnt++;
         slash_last_m = (ch == CH_SLASH);
      end else begin
         cut_m = 1'b1;
      end
   endfunction

   function automatic bit is_separator(logic [CHAR_W-1:0] c);
      return c == CH_SLASH || (cfg_m.backslash_separator && c == CH_BACKSLASH);
   endfunction

   function automatic bit is_alpha(logic [CHAR_W-1:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   function automatic void flush_drive_prefix();
      logic [CHAR_W-1:0] l;
      if (drive_seen_m && held_cnt != 0) begin
         l = held_letter;
         if (l >= CH_UPPER_A && l <= CH_UPPER_Z) l = l - CH_UPPER_A + CH_LOWER_A;
         send_char(l);
         send_char(CH_COLON);
         held_cnt = 2'd0;
      end
   endfunction

   function automatic void end_path(bit keep_dot);
      if (!keep_dot && (out_cnt == 0 || (drive_seen_m && out_cnt == 2)))
         send_char(CH_SLASH);
      put_byte(CH_NUL, 1'b1, cut_m);
      reset_path();
   endfunction

   function automatic void open_component(logic [CHAR_W-1:0] c, bit with_dot);
      if (out_cnt > 0 && !slash_last_m) send_char(CH_SLASH);
      if (with_dot) send_char(CH_DOT);
      send_char(c);
      ph_m = PH_COMP;
   endfunction

   function automatic void in_component(logic [CHAR_W-1:0] c);
      if (c == CH_NUL) end_path(1'b0);
      else if (is_separator(c)) ph_m = PH_SEP;
      else send_char(c);
   endfunction

   function automatic void after_separator(logic [CHAR_W-1:0] c);
      if (c == CH_NUL) end_path(1'b0);
      else if (is_separator(c)) ph_m = PH_SEP;
      else if (c == CH_DOT) ph_m = PH_DOT;
      else open_component(c, 1'b0);
   endfunction

   function automatic void at_prefix(logic [CHAR_W-1:0] c);
      if (c == CH_NUL) begin
         flush_drive_prefix();
         end_path(1'b0);
      end else if (is_separator(c)) begin
         flush_drive_prefix();
         if (cfg_m.unc_prefix_on) begin
            ph_m = PH_S1;
         end else begin
            send_char(CH_SLASH);
            ph_m = PH_SEP;
         end
      end else if (c == CH_DOT) begin
         ph_m = PH_PDOT;
      end else begin
         flush_drive_prefix();
         after_separator(c);
      end
   endfunction

   // expected output bytes for one accepted path byte
   function automatic void normalize_byte(logic [CHAR_W-1:0] c);
      step_n = 0;
      case (ph_m)
         PH_START: begin
            if (cfg_m.drive_letters_on && is_alpha(c)) begin
               held_letter = c;
               held_cnt    = 2'd1;
               ph_m        = PH_D1;
            end else begin
               at_prefix(c);
            end
         end
         PH_D1: begin
            if (c == CH_COLON) begin
               held_cnt     = 2'd2;
               drive_seen_m = 1'b1;
               ph_m         = PH_PRE;
            end else begin
               // no colon: the letter opens an ordinary name, case kept
               held_cnt = 2'd0;
               open_component(held_letter, 1'b0);
               in_component(c);
            end
         end
         PH_PRE: at_prefix(c);
         PH_S1: begin
            if (is_separator(c)) begin
               send_char(CH_SLASH);
               send_char(CH_SLASH);
               ph_m = PH_SEP;
            end else begin
               send_char(CH_SLASH);
               after_separator(c);
            end
         end
         PH_PDOT: begin
            if (c == CH_NUL) begin
               // lone dot passes through, drive letter unchanged
               if (drive_seen_m && held_cnt != 0) begin
                  send_char(held_letter);
                  send_char(CH_COLON);
               end
               send_char(CH_DOT);
               end_path(1'b1);
            end else if (is_separator(c)) begin
               flush_drive_prefix();
               send_char(CH_DOT);
               send_char(CH_SLASH);
               ph_m = PH_SEP;
            end else begin
               flush_drive_prefix();
               open_component(c, 1'b1);
            end
         end
         PH_SEP: after_separator(c);
         PH_DOT: begin
            if (c == CH_NUL) end_path(1'b0);
            else if (is_separator(c)) ph_m = PH_SEP;
            else open_component(c, 1'b1);
         end
         default: in_component(c);
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [CHAR_W-1:0] rand_letter();
      if ($urandom_range(0, 1) == 0) return CH_UPPER_A + 8'($urandom_range(0, 25));
      return CH_LOWER_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [CHAR_W-1:0] rand_sep();
      return ($urandom_range(0, 1) == 0) ? CH_SLASH : CH_BACKSLASH;
   endfunction

   function automatic logic [CHAR_W-1:0] noise_char();
      case ($urandom_range(0, 5))
         0:       return rand_sep();
         1:       return CH_DOT;
         2:       return CH_COLON;
         3:       return rand_letter();
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) pending_q.push_back(s[i]);
      pending_q.push_back(CH_NUL);
   endfunction

   // one terminated path, mostly well formed; returns the bytes queued
   function automatic int add_random_path();
      int start;
      int n;
      int k;
      int j;
      start = pending_q.size();
      if ($urandom_range(0, 5) == 0) begin
         n = $urandom_range(0, 8);
         for (k = 0; k < n; k++) pending_q.push_back(noise_char());
      end else begin
         if ($urandom_range(0, 2) == 0) begin
            pending_q.push_back(rand_letter());
            if ($urandom_range(0, 4) != 0) pending_q.push_back(CH_COLON);
         end
         case ($urandom_range(0, 5))
            1: pending_q.push_back(rand_sep());
            2: begin
               pending_q.push_back(rand_sep());
               pending_q.push_back(rand_sep());
            end
            3: pending_q.push_back(CH_DOT);
            4: begin
               pending_q.push_back(CH_DOT);
               pending_q.push_back(rand_sep());
            end
            default: ;
         endcase
         n = $urandom_range(0, 4);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
               0: pending_q.push_back(CH_DOT);
               1: begin
                  pending_q.push_back(CH_DOT);
                  pending_q.push_back(CH_DOT);
               end
               default: begin
                  for (j = $urandom_range(1, 4); j > 0; j--) begin
                     if ($urandom_range(0, 3) == 0) pending_q.push_back(noise_char());
                     else pending_q.push_back(rand_letter());
                  end
               end
            endcase
            if (k < n - 1 || $urandom_range(0, 2) == 0) begin
               for (j = $urandom_range(1, 3); j > 0; j--) pending_q.push_back(rand_sep());
            end
         end
      end
      pending_q.push_back(CH_NUL);
      return pending_q.size() - start;
   endfunction

   // keeps the write enable high across a series; caller lowers it
   task automatic write_csr(csr_index_type idx, logic [LIMIT_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_BACKSLASH: cfg_m.backslash_separator = val[0];
         CSR_DRIVE:     cfg_m.drive_letters_on    = val[0];
         CSR_UNC:       cfg_m.unc_prefix_on       = val[0];
         default:       cfg_m.length_limit        = val;
      endcase
   endtask

   task automatic apply_config(bit bs, bit drv, bit unc, logic [LIMIT_W-1:0] lim);
      write_csr(CSR_BACKSLASH, LIMIT_W'(bs));
      write_csr(CSR_DRIVE, LIMIT_W'(drv));
      write_csr(CSR_UNC, LIMIT_W'(unc));
      write_csr(CSR_LIMIT, lim);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (pending_q.size() > 0 || req_if.valid || norm_q.size() > 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   int gap_left;
   int burst_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.in_char <= CH_NUL;
         gap_left   = 0;
         burst_left = 1;
         cfg_m.backslash_separator = 1'b0;
         cfg_m.drive_letters_on    = 1'b0;
         cfg_m.unc_prefix_on       = 1'b0;
         cfg_m.length_limit        = LIMIT_RESET;
         reset_path();
      end else begin
         if (req_if.valid && req_if.ready) begin
            normalize_byte(req_if.in_char);
            bytes_in++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0 || pending_q.size() == 0) begin
               req_if.valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_if.valid   <= 1'b1;
               req_if.in_char <= pending_q.pop_front();
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   logic [15:0] ready_pattern;
   logic [3:0]  pattern_pos;
   int          pattern_age;

   always @(posedge clock) begin
      out_byte_type exp_b;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, norm_q.size());
         $display("path_normalizer_tb: errors");
         $finish;
      end
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         ready_pattern = 16'hffff;
         pattern_pos   = 4'd0;
         pattern_age   = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            bytes_checked++;
            if (norm_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer char %02h last %0b",
                                         rsp_if.out_char, rsp_if.last));
            end else begin
               exp_b = norm_q.pop_front();
               if (rsp_if.out_char !== exp_b.ch)
                  report_mismatch($sformatf("out_char %02h, expected %02h",
                                            rsp_if.out_char, exp_b.ch));
               if (rsp_if.last !== exp_b.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_if.last, exp_b.last));
               if (rsp_if.truncated !== exp_b.trunc)
                  report_mismatch($sformatf("truncated %0b, expected %0b",
                                            rsp_if.truncated, exp_b.trunc));
               if (exp_b.last) begin
                  paths_done++;
                  if (exp_b.trunc) paths_cut++;
               end
            end
         end
         // new stall pattern every so often: open, sparse, alternating or random
         pattern_age++;
         if (pattern_age >= 40) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
               0:       ready_pattern = 16'hffff;
               1:       ready_pattern = 16'($urandom) & 16'($urandom);
               2:       ready_pattern = 16'haaaa;
               default: ready_pattern = 16'($urandom);
            endcase
            ready_pattern[0] = 1'b1;
         end
         rsp_if.ready <= ready_pattern[pattern_pos];
         pattern_pos = pattern_pos + 4'd1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int p;
      int n;
      logic [LIMIT_W-1:0] lim;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_BACKSLASH;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.in_char = CH_NUL;
      rsp_if.ready   = 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      bytes_in       = 0;
      bytes_checked  = 0;
      paths_done     = 0;
      paths_cut      = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: empty path, leading dot, double slash folded
      add_text("");
      add_text("./a/");
      add_text("//x");
      wait_idle();

      // drive letters, backslash and UNC prefix on
      apply_config(1'b1, 1'b1, 1'b1, LIMIT_W'(MAX_LIM));
      add_text("C:.");
      add_text("z:");
      add_text("\\\\h");
      add_text("Ab");
      wait_idle();

      // smallest buffer: everything but the terminator is cut
      apply_config(1'b0, 1'b1, 1'b0, LIMIT_W'(1));
      add_text(".");
      add_text("ab");
      wait_idle();

      for (p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0:       lim = LIMIT_W'(MAX_LIM);
            1:       lim = '0;
            2:       lim = '1;
            3:       lim = LIMIT_W'(2);
            6:       lim = LIMIT_W'($urandom_range(1, MAX_LIM));
            default: lim = LIMIT_W'($urandom_range(3, 12));
         endcase
         apply_config(1'($urandom), 1'($urandom), 1'($urandom), lim);
         n = 0;
         while (n < PHASE_ITEMS) n += add_random_path();
         wait_idle();
      end

      if (norm_q.size() != 0)
         report_mismatch($sformatf("%0d expected bytes never arrived", norm_q.size()));
      $display("summary: %0d paths (%0d cut at the limit), %0d bytes in, %0d bytes out",
               paths_done, paths_cut, bytes_in, bytes_checked);
      $display("summary: %0d register settings, %0d mismatches", RAND_PHASES + 3,
               error_count);
      if (error_count == 0) begin
         $display("path_normalizer_tb: clean");
      end else begin
         $display("path_normalizer_tb: errors");
      end
      $finish;
   end

endmodule
